FILE: sv/tosm_pkg.sv
// Shared constants and types for the time ordered stream merge.
package tosm_pkg;

    // Stream geometry
    localparam int MAX_STREAMS = 16;
    localparam int STREAM_W    = 4;
    localparam int CNT_W       = 5;

    // Event fields
    localparam int TIME_W      = 64;
    localparam int PAYLOAD_W   = 64;
    localparam int HEAD_W      = TIME_W + PAYLOAD_W;

    // Stream buses, padded to whole bytes
    localparam int S_TDATA_W   = HEAD_W;
    localparam int M_TDATA_W   = ((HEAD_W + STREAM_W + 7) / 8) * 8;
    localparam int M_PAD_W     = M_TDATA_W - HEAD_W - STREAM_W;

    // Configuration port
    localparam int APB_ADDR_W  = 3;
    localparam int APB_DATA_W  = 32;
    localparam logic REG_STREAM_COUNT = 1'b0;

    // Sequencer states, one-hot
    typedef enum logic [2:0] {
        ST_IDLE = 3'b001,
        ST_SCAN = 3'b010,
        ST_EMIT = 3'b100
    } state_t;

    // Signed time order
    function automatic logic time_less(input logic [TIME_W-1:0] a,
                                       input logic [TIME_W-1:0] b);
        time_less = $signed(a) < $signed(b);
    endfunction

endpackage

FILE: sv/time_ordered_stream_merge.sv
// K-way time ordered merge of event streams with heads held in a memory.
//
//  channel  | direction | handshake         | contents
//  s_       | in        | s_tvalid/s_tready | tdata time+payload, tuser stream, tlast end
//  m_       | out       | m_tvalid/m_tready | tdata time+payload+stream, tuser event, tlast done
//  apb      | in/out    | psel/penable      | stream_count at byte address 0
//
// An item that causes no result is taken in the idle state, and an end mark that closes the
// last stream goes straight to the emit state. An item that completes a set of heads is
// accepted, then the scan reads the 16 x 128 head memory once per active stream with one
// comparator and finishes the last compare, then the output register loads once m_ is free.
// Reset clears the head and end flags; the head memory needs no clearing.
// A result waiting on m_ does not block accepts until the next result is ready.
module time_ordered_stream_merge (
    input  logic                               aclk,
    input  logic                               aresetn,
    // input stream
    input  logic                               s_tvalid,
    output logic                               s_tready,
    input  logic [tosm_pkg::S_TDATA_W-1:0]     s_tdata,   // event_time, event_payload
    input  logic [tosm_pkg::STREAM_W-1:0]      s_tuser,   // stream_index
    input  logic                               s_tlast,   // end_of_stream
    // result stream
    output logic                               m_tvalid,
    input  logic                               m_tready,
    output logic [tosm_pkg::M_TDATA_W-1:0]     m_tdata,   // out_time, out_payload, out_stream
    output logic                               m_tuser,   // event_present
    output logic                               m_tlast,   // all_done
    // configuration
    input  logic                               psel,
    input  logic                               penable,
    input  logic                               pwrite,
    input  logic [tosm_pkg::APB_ADDR_W-1:0]    paddr,
    input  logic [tosm_pkg::APB_DATA_W-1:0]    pwdata,
    output logic [tosm_pkg::APB_DATA_W-1:0]    prdata,
    output logic                               pready
);

    localparam int MS = tosm_pkg::MAX_STREAMS;
    localparam int SW = tosm_pkg::STREAM_W;
    localparam int CW = tosm_pkg::CNT_W;
    localparam int TW = tosm_pkg::TIME_W;
    localparam int PW = tosm_pkg::PAYLOAD_W;
    localparam int HW = tosm_pkg::HEAD_W;

    // Head memory
    logic [HW-1:0] head_mem [MS];
    logic [HW-1:0] rd_data_reg;
    logic          mem_we;
    logic          mem_re;
    logic [SW-1:0] mem_raddr;

    // Control state
    tosm_pkg::state_t state_reg, state_next;
    logic [MS-1:0] head_valid_reg, head_valid_next;
    logic [MS-1:0] stream_ended_reg, stream_ended_next;
    logic [CW-1:0] stream_count_reg;
    logic [CW-1:0] rd_idx_reg, rd_idx_next;
    logic          pend_reg, pend_next;
    logic [SW-1:0] pend_idx_reg, pend_idx_next;
    logic          found_reg, found_next;
    logic          done_reg, done_next;
    logic          m_tvalid_reg, m_tvalid_next;

    // Payload registers
    logic [TW-1:0] best_time_reg, best_time_next;
    logic [PW-1:0] best_payload_reg, best_payload_next;
    logic [SW-1:0] best_idx_reg, best_idx_next;
    logic [tosm_pkg::M_TDATA_W-1:0] m_tdata_reg, m_tdata_next;
    logic          m_tuser_reg, m_tuser_next;
    logic          m_tlast_reg, m_tlast_next;

    // Decoded input transfer
    logic          s_xfer;
    logic          cfg_wr;
    logic [CW-1:0] n_active;
    logic [MS-1:0] act_mask;
    logic [MS-1:0] sel_mask;
    logic [MS-1:0] open_mask;
    logic          in_range;
    logic          take_item;
    logic          end_taken;
    logic          issue;
    logic          eligible;
    logic          out_free;

    assign s_xfer   = s_tvalid && s_tready;
    assign s_tready = (state_reg == tosm_pkg::ST_IDLE);
    assign out_free = !m_tvalid_reg || m_tready;

    // Configuration register
    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite
                    && (paddr[2] == tosm_pkg::REG_STREAM_COUNT);
    assign prdata = (paddr[2] == tosm_pkg::REG_STREAM_COUNT)
                    ? {{(tosm_pkg::APB_DATA_W-CW){1'b0}}, stream_count_reg}
                    : '0;

    // Active count clamped to 1..MAX_STREAMS
    always_comb begin
        if (stream_count_reg == '0) begin
            n_active = CW'(1);
        end else if (stream_count_reg > CW'(MS)) begin
            n_active = CW'(MS);
        end else begin
            n_active = stream_count_reg;
        end
        for (int i = 0; i < MS; i++) begin
            act_mask[i] = (CW'(i) < n_active);
        end
    end

    assign sel_mask  = MS'(1) << s_tuser;
    assign in_range  = {1'b0, s_tuser} < n_active;
    assign take_item = s_xfer && in_range && !stream_ended_reg[s_tuser]
                       && !head_valid_reg[s_tuser];
    assign end_taken = take_item && s_tlast;
    assign mem_we    = take_item && !s_tlast;

    // Scan read side
    assign issue     = (state_reg == tosm_pkg::ST_SCAN) && (rd_idx_reg < n_active);
    assign mem_re    = issue;
    assign mem_raddr = rd_idx_reg[SW-1:0];
    assign eligible  = pend_reg && !stream_ended_reg[pend_idx_reg];

    // Sequencer
    always_comb begin
        state_next        = state_reg;
        head_valid_next   = head_valid_reg;
        stream_ended_next = stream_ended_reg;
        rd_idx_next       = rd_idx_reg;
        pend_next         = 1'b0;
        pend_idx_next     = rd_idx_reg[SW-1:0];
        found_next        = found_reg;
        done_next         = done_reg;
        best_time_next    = best_time_reg;
        best_payload_next = best_payload_reg;
        best_idx_next     = best_idx_reg;
        m_tvalid_next     = m_tvalid_reg;
        m_tdata_next      = m_tdata_reg;
        m_tuser_next      = m_tuser_reg;
        m_tlast_next      = m_tlast_reg;
        open_mask         = '0;

        // output register drains on a completed transfer
        if (m_tready) begin
            m_tvalid_next = 1'b0;
        end

        case (state_reg)
            tosm_pkg::ST_IDLE: begin
                if (s_xfer) begin
                    if (end_taken) begin
                        stream_ended_next = stream_ended_reg | sel_mask;
                    end
                    if (mem_we) begin
                        head_valid_next = head_valid_reg | sel_mask;
                    end
                    open_mask   = act_mask & ~stream_ended_next;
                    rd_idx_next = '0;
                    found_next  = 1'b0;
                    if (end_taken && (open_mask == '0)) begin
                        done_next  = 1'b1;
                        state_next = tosm_pkg::ST_EMIT;
                    end else if ((open_mask != '0)
                                 && ((open_mask & ~head_valid_next) == '0)) begin
                        done_next  = 1'b0;
                        state_next = tosm_pkg::ST_SCAN;
                    end
                end
            end
            tosm_pkg::ST_SCAN: begin
                if (issue) begin
                    rd_idx_next = rd_idx_reg + CW'(1);
                    pend_next   = 1'b1;
                end
                // one compare per returned head
                if (eligible && (!found_reg
                        || tosm_pkg::time_less(rd_data_reg[TW-1:0], best_time_reg))) begin
                    found_next        = 1'b1;
                    best_time_next    = rd_data_reg[TW-1:0];
                    best_payload_next = rd_data_reg[HW-1:TW];
                    best_idx_next     = pend_idx_reg;
                end
                if (!issue && !pend_reg) begin
                    state_next = tosm_pkg::ST_EMIT;
                end
            end
            tosm_pkg::ST_EMIT: begin
                if (out_free) begin
                    m_tvalid_next = 1'b1;
                    m_tlast_next  = done_reg;
                    m_tuser_next  = !done_reg;
                    if (done_reg) begin
                        m_tdata_next = '0;
                    end else begin
                        m_tdata_next = {{tosm_pkg::M_PAD_W{1'b0}}, best_idx_reg,
                                        best_payload_reg, best_time_reg};
                        head_valid_next = head_valid_reg & ~(MS'(1) << best_idx_reg);
                    end
                    state_next = tosm_pkg::ST_IDLE;
                end
            end
            default: begin
                state_next = tosm_pkg::ST_IDLE;
            end
        endcase
    end

    // Head memory, one write and one registered read port
    always_ff @(posedge aclk) begin
        if (mem_we) begin
            head_mem[s_tuser] <= s_tdata;
        end
        if (mem_re) begin
            rd_data_reg <= head_mem[mem_raddr];
        end
    end

    // Control registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg        <= tosm_pkg::ST_IDLE;
            head_valid_reg   <= '0;
            stream_ended_reg <= '0;
            stream_count_reg <= CW'(1);
            rd_idx_reg       <= '0;
            pend_reg         <= 1'b0;
            found_reg        <= 1'b0;
            done_reg         <= 1'b0;
            m_tvalid_reg     <= 1'b0;
        end else begin
            state_reg        <= state_next;
            head_valid_reg   <= head_valid_next;
            stream_ended_reg <= stream_ended_next;
            rd_idx_reg       <= rd_idx_next;
            pend_reg         <= pend_next;
            found_reg        <= found_next;
            done_reg         <= done_next;
            m_tvalid_reg     <= m_tvalid_next;
            if (cfg_wr) begin
                stream_count_reg <= pwdata[CW-1:0];
            end
        end
    end

    // Payload registers
    always_ff @(posedge aclk) begin
        pend_idx_reg     <= pend_idx_next;
        best_time_reg    <= best_time_next;
        best_payload_reg <= best_payload_next;
        best_idx_reg     <= best_idx_next;
        m_tdata_reg      <= m_tdata_next;
        m_tuser_reg      <= m_tuser_next;
        m_tlast_reg      <= m_tlast_next;
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;
    assign m_tuser  = m_tuser_reg;
    assign m_tlast  = m_tlast_reg;

`ifndef ASSERT_OFF
    // an ended stream never keeps a head
    a_valid_not_ended: assert property (@(posedge aclk) disable iff (!aresetn)
        (head_valid_reg & stream_ended_reg) == '0)
        else $error("head held for ended stream");

    // an event result always clears a head that is really held
    a_emit_head_held: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == tosm_pkg::ST_EMIT) && !done_reg |-> head_valid_reg[best_idx_reg])
        else $error("emitting stream without a head");

    // the scan reaches the emit state with a winner found
    a_scan_found: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == tosm_pkg::ST_SCAN) && !issue && !pend_reg |-> found_reg)
        else $error("scan ended without a winner");

    // all_done and an event never share a result
    a_done_no_event: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid_reg |-> (m_tlast_reg != m_tuser_reg))
        else $error("result flags inconsistent");

    // the scan index stays within the memory depth
    a_idx_range: assert property (@(posedge aclk) disable iff (!aresetn)
        rd_idx_reg <= CW'(MS))
        else $error("scan index out of range");
`endif

endmodule

FILE: sim/time_ordered_stream_merge_tb.sv
// Self-checking testbench for the time ordered stream merge: directed table, then random merges.
module time_ordered_stream_merge_tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int MAX_STREAMS = tosm_pkg::MAX_STREAMS;
    localparam int STREAM_W    = tosm_pkg::STREAM_W;
    localparam int CNT_W       = tosm_pkg::CNT_W;
    localparam int TIME_W      = tosm_pkg::TIME_W;
    localparam int PAYLOAD_W   = tosm_pkg::PAYLOAD_W;
    localparam int HEAD_W      = tosm_pkg::HEAD_W;
    localparam int S_TDATA_W   = tosm_pkg::S_TDATA_W;
    localparam int M_TDATA_W   = tosm_pkg::M_TDATA_W;
    localparam int APB_ADDR_W  = tosm_pkg::APB_ADDR_W;
    localparam int APB_DATA_W  = tosm_pkg::APB_DATA_W;

    localparam int HALF_PERIOD     = 6;
    localparam int RESET_CYCLES    = 10;
    localparam int SETTLE_CYCLES   = MAX_STREAMS + 8;
    localparam int STALL_LIMIT     = 2000;
    localparam int ITEMS_PER_PHASE = 275;
    localparam int NUM_PHASES      = 6;
    // Counts for the random phases: partial, above max, shrink, regrow, above max, full width
    localparam int PHASE_COUNTS [NUM_PHASES] = '{7, 31, 4, 12, 17, 16};

    localparam logic [APB_ADDR_W-1:0] COUNT_ADDR =
        APB_ADDR_W'(4 * int'(tosm_pkg::REG_STREAM_COUNT));

    localparam logic [TIME_W-1:0] T_MIN    = 64'h8000_0000_0000_0000;
    localparam logic [TIME_W-1:0] T_MAX    = 64'h7FFF_FFFF_FFFF_FFFF;
    localparam logic [TIME_W-1:0] T_ONE    = 64'h0000_0001_0000_0000;
    localparam logic [TIME_W-1:0] T_NEG1   = 64'hFFFF_FFFF_0000_0000;

    // One merged result as seen on m_
    typedef struct packed {
        logic [TIME_W-1:0]    t;
        logic [PAYLOAD_W-1:0] pay;
        logic [STREAM_W-1:0]  strm;
        logic                 present;
        logic                 done;
    } merge_out_t;

    // Directed table: how each row's result is known
    typedef enum logic [2:0] {
        ROW_PRED,   // from the predictor
        ROW_NONE,   // no result
        ROW_ECHO,   // the event itself comes straight back
        ROW_DONE,   // all-done marker
        ROW_CFG     // stream_count write, value in pay
    } row_kind_t;

    typedef struct packed {
        row_kind_t            kind;
        logic [STREAM_W-1:0]  strm;
        logic                 eos;
        logic [TIME_W-1:0]    t;
        logic [PAYLOAD_W-1:0] pay;
    } row_t;

    localparam int PLAN_LEN = 20;
    localparam row_t PLAN [PLAN_LEN] = '{
        // reset count of one: every event on stream 0 comes straight back
        '{ROW_ECHO, 4'd0,  1'b0, T_MIN,  64'h0},
        '{ROW_ECHO, 4'd0,  1'b0, T_MAX,  64'hFFFF_FFFF_FFFF_FFFF},
        '{ROW_NONE, 4'd3,  1'b0, 64'h5555_5555_5555_5555, 64'hAAAA_AAAA_AAAA_AAAA},
        '{ROW_ECHO, 4'd0,  1'b0, 64'h0,  64'h0123_4567_89AB_CDEF},
        // count of zero behaves as one
        '{ROW_CFG,  4'd0,  1'b0, 64'h0,  64'd0},
        '{ROW_NONE, 4'd15, 1'b0, 64'hFFFF_FFFF_FFFF_FFFF, 64'h5A5A_5A5A_5A5A_5A5A},
        '{ROW_ECHO, 4'd0,  1'b0, T_NEG1, 64'hFEDC_BA98_7654_3210},
        '{ROW_DONE, 4'd0,  1'b1, 64'h0,  64'h0},
        // anything for an ended stream is dropped
        '{ROW_NONE, 4'd0,  1'b0, T_ONE,  64'h1},
        '{ROW_NONE, 4'd0,  1'b1, 64'h0,  64'h0},
        // two open streams: held head, ties, late end marks
        '{ROW_CFG,  4'd0,  1'b0, 64'h0,  64'd3},
        '{ROW_PRED, 4'd1,  1'b0, 64'h5_0000_0000, 64'h1111_1111_1111_1111},
        '{ROW_PRED, 4'd1,  1'b0, 64'h3_0000_0000, 64'h2222_2222_2222_2222},
        '{ROW_PRED, 4'd1,  1'b1, 64'h0,  64'h0},
        '{ROW_PRED, 4'd2,  1'b0, 64'h5_0000_0000, 64'h3333_3333_3333_3333},
        '{ROW_PRED, 4'd1,  1'b0, T_NEG1, 64'h4444_4444_4444_4444},
        '{ROW_PRED, 4'd1,  1'b0, 64'h7_0000_0000, 64'h5555_5555_5555_5555},
        '{ROW_PRED, 4'd2,  1'b1, 64'h0,  64'h0},
        '{ROW_DONE, 4'd1,  1'b1, 64'h0,  64'h0},
        '{ROW_NONE, 4'd2,  1'b0, T_ONE,  64'h6666_6666_6666_6666}
    };

    logic                   aclk     = 1'b0;
    logic                   aresetn  = 1'b0;
    logic                   s_tvalid = 1'b0;
    logic                   s_tready;
    logic [S_TDATA_W-1:0]   s_tdata  = '0;    // event_time, event_payload
    logic [STREAM_W-1:0]    s_tuser  = '0;    // stream_index
    logic                   s_tlast  = 1'b0;  // end_of_stream
    logic                   m_tvalid;
    logic                   m_tready = 1'b0;
    logic [M_TDATA_W-1:0]   m_tdata;          // out_time, out_payload, out_stream
    logic                   m_tuser;          // event_present
    logic                   m_tlast;          // all_done
    logic                   psel     = 1'b0;
    logic                   penable  = 1'b0;
    logic                   pwrite   = 1'b0;
    logic [APB_ADDR_W-1:0]  paddr    = '0;
    logic [APB_DATA_W-1:0]  pwdata   = '0;
    logic [APB_DATA_W-1:0]  prdata;
    logic                   pready;

    time_ordered_stream_merge DUT (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .s_tlast  (s_tlast),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready)
    );

    always begin
        #HALF_PERIOD aclk = 1'b1;
        #HALF_PERIOD aclk = 1'b0;
    end

    // Mirror of the merge state
    logic [TIME_W-1:0]      held_time    [MAX_STREAMS];
    logic [PAYLOAD_W-1:0]   held_payload [MAX_STREAMS];
    logic [MAX_STREAMS-1:0] held_mask  = '0;
    logic [MAX_STREAMS-1:0] ended_mask = '0;
    logic [CNT_W-1:0]       count_reg  = CNT_W'(1);

    merge_out_t merged_q [$];
    int         mismatch_count = 0;
    int         stall_cycles   = 0;
    int         hold_left      = 0;
    bit         calm           = 1'b0;
    merge_out_t seen;
    merge_out_t want;

    // Per-stream running time for in-order random events
    logic [TIME_W-1:0] last_time [MAX_STREAMS];

    function automatic int eff_count();
        if (count_reg == 0) return 1;
        if (count_reg > MAX_STREAMS) return MAX_STREAMS;
        return int'(count_reg);
    endfunction

    function automatic int open_count();
        int n;
        n = 0;
        for (int i = 0; i < eff_count(); i++)
            if (!ended_mask[i]) n++;
        return n;
    endfunction

    // Applies one input item; returns 1 with the merged result when one is due
    function automatic bit merge_predict(input logic [STREAM_W-1:0] strm, input logic eos,
                                         input logic [TIME_W-1:0] t,
                                         input logic [PAYLOAD_W-1:0] pay,
                                         output merge_out_t r);
        int  n;
        int  best;
        bit  found;
        n = eff_count();
        r = '0;
        if (int'(strm) < n && !ended_mask[strm]) begin
            if (eos) begin
                // end mark only counts once the head has been drained
                if (!held_mask[strm]) begin
                    ended_mask[strm] = 1'b1;
                    if (open_count() == 0) begin
                        r.done = 1'b1;
                        return 1'b1;
                    end
                end
            end else if (!held_mask[strm]) begin
                held_time[strm]    = t;
                held_payload[strm] = pay;
                held_mask[strm]    = 1'b1;
            end
        end
        // emit only when every open stream holds a head; lowest index wins ties
        found = 1'b0;
        best  = 0;
        for (int i = 0; i < n; i++) begin
            if (ended_mask[i]) continue;
            if (!held_mask[i]) return 1'b0;
            if (!found || $signed(held_time[i]) < $signed(held_time[best])) begin
                best  = i;
                found = 1'b1;
            end
        end
        if (!found) return 1'b0;
        r.t       = held_time[best];
        r.pay     = held_payload[best];
        r.strm    = STREAM_W'(best);
        r.present = 1'b1;
        held_mask[best] = 1'b0;
        return 1'b1;
    endfunction

    // Random open stream still waiting for its head, or -1
    function automatic int pick_hungry();
        int cand [$];
        for (int i = 0; i < eff_count(); i++)
            if (!ended_mask[i] && !held_mask[i]) cand.push_back(i);
        if (cand.size() == 0) return -1;
        return cand[$urandom_range(0, cand.size() - 1)];
    endfunction

    // Mostly back to back, sometimes short gaps, rarely long ones
    function automatic int gap_len();
        int r;
        r = $urandom_range(0, 99);
        if (calm || r < 60) return 0;
        if (r < 92) return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    task automatic report(input string what, input merge_out_t exp_r, input merge_out_t act_r);
        if (mismatch_count < 10)
            $display({"%0t %s: exp t=%h pay=%h strm=%0d ev=%b done=%b,",
                      " got t=%h pay=%h strm=%0d ev=%b done=%b"},
                     $realtime, what, exp_r.t, exp_r.pay, exp_r.strm, exp_r.present, exp_r.done,
                     act_r.t, act_r.pay, act_r.strm, act_r.present, act_r.done);
        mismatch_count++;
    endtask

    // Result side: check each transfer, then pick the next ready level
    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready) begin
            seen.t       = m_tdata[TIME_W-1:0];
            seen.pay     = m_tdata[HEAD_W-1:TIME_W];
            seen.strm    = m_tdata[HEAD_W+STREAM_W-1:HEAD_W];
            seen.present = m_tuser;
            seen.done    = m_tlast;
            if (merged_q.size() == 0) begin
                report("unexpected result", '0, seen);
            end else begin
                want = merged_q.pop_front();
                if (seen.t !== want.t || seen.pay !== want.pay || seen.strm !== want.strm ||
                    seen.present !== want.present || seen.done !== want.done)
                    report("result mismatch", want, seen);
            end
        end
        if (hold_left != 0) begin
            hold_left <= hold_left - 1;
        end else begin
            m_tready  <= calm || ($urandom_range(0, 3) != 0);
            hold_left <= gap_len();
        end
    end

    // Watchdog on cycles with no transfer anywhere
    always @(posedge aclk) begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (psel && penable)) begin
            stall_cycles <= 0;
        end else if (stall_cycles >= STALL_LIMIT) begin
            $display("time_ordered_stream_merge_tb: errors");
            $finish;
        end else begin
            stall_cycles <= stall_cycles + 1;
        end
    end

    // Present one item and hold it until the transfer; valid stays up for the next one
    task automatic drive_item(input logic [STREAM_W-1:0] strm, input logic eos,
                              input logic [TIME_W-1:0] t, input logic [PAYLOAD_W-1:0] pay);
        int gap;
        gap = gap_len();
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {pay, t};
        s_tuser  <= strm;
        s_tlast  <= eos;
        do @(posedge aclk); while (!s_tready);
    endtask

    task automatic issue(input logic [STREAM_W-1:0] strm, input logic eos,
                         input logic [TIME_W-1:0] t, input logic [PAYLOAD_W-1:0] pay);
        merge_out_t r;
        if (merge_predict(strm, eos, t, pay, r)) merged_q.push_back(r);
        drive_item(strm, eos, t, pay);
    endtask

    // Wait for all results plus the block's scan time before touching the register
    task automatic settle();
        s_tvalid <= 1'b0;
        while (merged_q.size() != 0) @(posedge aclk);
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    // Write stream_count with junk in the unused bits, then read it back
    task automatic write_count(input logic [CNT_W-1:0] value);
        logic [APB_DATA_W-1:0] word;
        word           = $urandom;
        word[CNT_W-1:0] = value;
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= COUNT_ADDR;
        pwdata  <= word;
        @(posedge aclk);
        penable <= 1'b1;
        do @(posedge aclk); while (!pready);
        count_reg = value;
        pwrite  <= 1'b0;
        penable <= 1'b0;
        @(posedge aclk);
        penable <= 1'b1;
        do @(posedge aclk); while (!pready);
        if (prdata[CNT_W-1:0] !== value) begin
            if (mismatch_count < 10)
                $display("%0t stream_count readback: exp %0d got %0d",
                         $realtime, value, prdata[CNT_W-1:0]);
            mismatch_count++;
        end
        psel    <= 1'b0;
        penable <= 1'b0;
    endtask

    initial begin
        merge_out_t            r;
        row_t                  row;
        bit                    due;
        int                    pick;
        int                    roll;
        logic [STREAM_W-1:0]   strm;
        logic                  eos;
        logic [TIME_W-1:0]     t;
        logic [TIME_W-1:0]     base;
        logic [TIME_W-1:0]     step;

        repeat (RESET_CYCLES) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Directed table
        for (int k = 0; k < PLAN_LEN; k++) begin
            row = PLAN[k];
            if (row.kind == ROW_CFG) begin
                settle();
                write_count(row.pay[CNT_W-1:0]);
            end else begin
                due = merge_predict(row.strm, row.eos, row.t, row.pay, r);
                case (row.kind)
                    ROW_PRED: if (due) merged_q.push_back(r);
                    ROW_ECHO: merged_q.push_back(merge_out_t'{t: row.t, pay: row.pay,
                                                              strm: row.strm,
                                                              present: 1'b1, done: 1'b0});
                    ROW_DONE: merged_q.push_back(merge_out_t'{t: '0, pay: '0, strm: '0,
                                                              present: 1'b0, done: 1'b1});
                    default: ;
                endcase
                drive_item(row.strm, row.eos, row.t, row.pay);
            end
        end

        // Random phases: in-order events on waiting streams, some noise, a few ends
        for (int ph = 0; ph < NUM_PHASES; ph++) begin
            settle();
            write_count(CNT_W'(PHASE_COUNTS[ph]));
            base = {$urandom, $urandom};
            base = TIME_W'($signed(base) >>> 3);
            for (int i = 0; i < MAX_STREAMS; i++) last_time[i] = base;
            repeat (ITEMS_PER_PHASE) begin
                if ($urandom_range(0, 59) == 0) calm = !calm;
                pick = pick_hungry();
                roll = $urandom_range(0, 99);
                if (pick >= 0 && roll < 85) begin
                    if (roll < 2 && open_count() > 2) begin
                        issue(STREAM_W'(pick), 1'b1, {$urandom, $urandom}, {$urandom, $urandom});
                    end else begin
                        step = TIME_W'($urandom_range(0, 3)) <<
                               ($urandom_range(0, 1) ? 32 : $urandom_range(0, 31));
                        last_time[pick] = last_time[pick] + step;
                        issue(STREAM_W'(pick), 1'b0, last_time[pick], {$urandom, $urandom});
                    end
                end else begin
                    strm = STREAM_W'($urandom_range(0, MAX_STREAMS - 1));
                    eos  = ($urandom_range(0, 3) == 0);
                    // keep stray end marks from closing too many streams
                    if (eos && int'(strm) < eff_count() && !ended_mask[strm] &&
                        !held_mask[strm] && open_count() <= 2)
                        eos = 1'b0;
                    issue(strm, eos, {$urandom, $urandom}, {$urandom, $urandom});
                end
            end
        end

        // Close every remaining stream; the last end mark brings all_done
        while (open_count() > 0) begin
            pick = pick_hungry();
            if (pick < 0) break;
            t = {$urandom, $urandom};
            issue(STREAM_W'(pick), 1'b1, t, {$urandom, $urandom});
        end

        settle();
        if (mismatch_count == 0 && merged_q.size() == 0) begin
            $display("time_ordered_stream_merge_tb: clean");
        end else begin
            $display("time_ordered_stream_merge_tb: errors");
        end
        $finish;
    end

endmodule
